>>> hw/rtl/printer_text_filter_roman8_unit_defines.svh
// Assertion macros shared by the filter's RTL files.
`ifndef PRINTER_TEXT_FILTER_ROMAN8_UNIT_DEFINES_SVH
`define PRINTER_TEXT_FILTER_ROMAN8_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTFR8_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptfr8 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTFR8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptfr8 assertion failed");

`endif

>>> hw/rtl/ptfr8_pkg.sv
`default_nettype none

package ptfr8_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_file;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_status;

    // Escape sequence modes.
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_FIRST = 2'd1;
    localparam logic [1:0] ESC_BODY  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LOWZ  = 8'h7A;
    localparam logic [7:0] HIGH_BASE = 8'hA0;

    localparam int unsigned COL_W = 16;
    localparam int unsigned TAB_W = 3;

    localparam logic [7:0] ROMAN8_MAP [96] = '{
        8'ha0, 8'hb8, 8'hbf, 8'hbb, 8'hba, 8'hbc, 8'h20, 8'hbd,
        8'hab, 8'h20, 8'hf9, 8'hfb, 8'h20, 8'hf6, 8'h20, 8'hb0,
        8'hb3, 8'hfe, 8'h20, 8'h20, 8'ha8, 8'h20, 8'h20, 8'hfc,
        8'h20, 8'h20, 8'hfa, 8'hfd, 8'hf7, 8'hf8, 8'h20, 8'hb9,
        8'ha1, 8'he0, 8'ha2, 8'he1, 8'hd8, 8'hd0, 8'hd3, 8'hb4,
        8'ha3, 8'hdc, 8'ha4, 8'ha5, 8'he6, 8'he5, 8'ha6, 8'ha7,
        8'he3, 8'hb6, 8'he8, 8'he7, 8'hdf, 8'he9, 8'hda, 8'h20,
        8'hd2, 8'had, 8'hed, 8'hae, 8'hdb, 8'h20, 8'hf1, 8'hde,
        8'hc8, 8'hc4, 8'hc0, 8'he2, 8'hcc, 8'hd4, 8'hd7, 8'hb5,
        8'hc9, 8'hc5, 8'hc1, 8'hcd, 8'hd9, 8'hd5, 8'hd1, 8'hdd,
        8'he4, 8'hb7, 8'hca, 8'hc6, 8'hc2, 8'hea, 8'hce, 8'h20,
        8'hd6, 8'hcb, 8'hc7, 8'hc3, 8'hcf, 8'h20, 8'hf0, 8'hef
    };

endpackage

`default_nettype wire

>>> hw/rtl/ptfr8_dpath.sv
`default_nettype none
`include "printer_text_filter_roman8_unit_defines.svh"

module ptfr8_dpath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ptfr8_pkg::t_dp_cmd   i_cmd,
    input  wire ptfr8_pkg::t_in_item  i_in_data,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_wdata,
    output ptfr8_pkg::t_out_item      o_out_data,
    output ptfr8_pkg::t_dp_status     o_status
);

    logic [ptfr8_pkg::COL_W-1:0] r_col, n_col;
    logic [1:0]                  r_esc, n_esc;
    logic                        r_bypass;
    logic [7:0]                  r_out_byte, n_out_byte;
    logic [7:0]                  r_next_byte, n_next_byte;
    logic [ptfr8_pkg::TAB_W-1:0] r_remaining, n_remaining;
    logic                        r_last, n_last;

    logic [7:0]                  b;
    logic [1:0]                  mode;
    logic                        ends_seq;
    logic [7:0]                  mapped;
    logic [6:0]                  map_idx;
    logic [ptfr8_pkg::TAB_W:0]   tab_sp;
    logic [ptfr8_pkg::TAB_W:0]   count;
    logic [ptfr8_pkg::TAB_W:0]   inc;
    logic [ptfr8_pkg::COL_W:0]   col_sum;
    logic [ptfr8_pkg::COL_W-1:0] col_sat;
    logic [6:0]                  low7;

    always_comb begin
        b        = i_in_data.in_byte;
        mode     = i_in_data.start_of_file ? ptfr8_pkg::ESC_NONE : r_esc;
        ends_seq = (b >= ptfr8_pkg::CH_AT) && (b <= ptfr8_pkg::CH_UPZ);
        map_idx  = 7'(b - ptfr8_pkg::HIGH_BASE);
        mapped   = (b >= ptfr8_pkg::HIGH_BASE && !r_bypass) ?
                   ptfr8_pkg::ROMAN8_MAP[map_idx] : b;
        low7     = mapped[6:0];
        tab_sp   = (ptfr8_pkg::TAB_W+1)'(8) - {1'b0, r_col[ptfr8_pkg::TAB_W-1:0]};
        inc      = '0;

        n_esc       = mode;
        n_out_byte  = b;
        n_next_byte = ptfr8_pkg::CH_SPACE;
        count       = (ptfr8_pkg::TAB_W+1)'(1);
        n_col       = r_col;

        if (mode == ptfr8_pkg::ESC_FIRST) begin
            n_esc = (b == ptfr8_pkg::CH_LOWZ || b == ptfr8_pkg::CH_EQ || ends_seq) ?
                    ptfr8_pkg::ESC_NONE : ptfr8_pkg::ESC_BODY;
        end else if (mode != ptfr8_pkg::ESC_NONE) begin
            if (ends_seq) begin
                n_esc = ptfr8_pkg::ESC_NONE;
            end
        end else begin
            case (b)
                ptfr8_pkg::CH_BS: begin
                    if (r_col != '0) begin
                        n_col = r_col - 1'b1;
                    end
                end
                ptfr8_pkg::CH_TAB: begin
                    n_out_byte = ptfr8_pkg::CH_SPACE;
                    count      = tab_sp;
                    inc        = tab_sp;
                end
                ptfr8_pkg::CH_LF: begin
                    n_next_byte = ptfr8_pkg::CH_CR;
                    count       = (ptfr8_pkg::TAB_W+1)'(2);
                    n_col       = '0;
                end
                ptfr8_pkg::CH_CR: begin
                    n_col = '0;
                end
                ptfr8_pkg::CH_ESC: begin
                    n_esc = ptfr8_pkg::ESC_FIRST;
                end
                default: begin
                    n_out_byte = mapped;
                    if (low7 >= ptfr8_pkg::CH_SPACE[6:0] && low7 < ptfr8_pkg::CH_DEL[6:0]) begin
                        inc = (ptfr8_pkg::TAB_W+1)'(1);
                    end
                end
            endcase
        end

        // Column advances saturate at the counter's top value.
        col_sum = {1'b0, r_col} + (ptfr8_pkg::COL_W+1)'(inc);
        col_sat = col_sum[ptfr8_pkg::COL_W] ? '1 : col_sum[ptfr8_pkg::COL_W-1:0];
        if (inc != '0) begin
            n_col = col_sat;
        end

        n_remaining = ptfr8_pkg::TAB_W'(count - 1'b1);
        n_last      = (count == (ptfr8_pkg::TAB_W+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_esc       <= ptfr8_pkg::ESC_NONE;
            r_bypass    <= 1'b0;
            r_remaining <= '0;
            r_last      <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_bypass <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_col       <= n_col;
                r_esc       <= n_esc;
                r_remaining <= n_remaining;
                r_last      <= n_last;
            end else if (i_cmd.advance) begin
                r_remaining <= r_remaining - 1'b1;
                r_last      <= (r_remaining == ptfr8_pkg::TAB_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte  <= n_out_byte;
            r_next_byte <= n_next_byte;
        end else if (i_cmd.advance) begin
            r_out_byte <= r_next_byte;
        end
    end

    assign o_out_data.out_byte = r_out_byte;
    assign o_out_data.last     = r_last;
    assign o_status.last       = r_last;

    `PTFR8_ASSERT_NOW(a_last_matches_count, i_clk, i_rst_n, 1'b1, r_last == (r_remaining == '0))
    `PTFR8_ASSERT_NOW(a_no_pop_past_last, i_clk, i_rst_n, i_cmd.advance, !r_last && !i_cmd.load)

endmodule

`default_nettype wire

>>> hw/rtl/ptfr8_ctrl.sv
`default_nettype none
`include "printer_text_filter_roman8_unit_defines.svh"

module ptfr8_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_out_stall,
    input  wire ptfr8_pkg::t_dp_status  i_status,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output ptfr8_pkg::t_dp_cmd          o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   load;
    logic   taken;

    always_comb begin
        taken       = (r_state == S_EMIT) && !i_out_stall;
        // A new request may enter in the cycle the final byte of the previous one leaves.
        o_in_stall  = (r_state == S_EMIT) && !(taken && i_status.last);
        load        = i_in_valid && !o_in_stall;
        o_out_valid = (r_state == S_EMIT);
        o_cmd.load    = load;
        o_cmd.advance = taken && !i_status.last;

        case (r_state)
            S_IDLE: n_state = load ? S_EMIT : S_IDLE;
            S_EMIT: n_state = (taken && i_status.last && !load) ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PTFR8_ASSERT_NEXT(a_load_shows_output, i_clk, i_rst_n, load, r_state == S_EMIT)
    `PTFR8_ASSERT_NEXT(a_hold_unfinished, i_clk, i_rst_n, (r_state == S_EMIT) && !i_status.last, r_state == S_EMIT)

endmodule

`default_nettype wire

>>> hw/rtl/printer_text_filter_roman8_unit.sv
`default_nettype none

// Printer text filter: takes one Latin-1 byte per request and sends one to eight
// bytes to the printer, expanding tabs, turning newline into LF CR, tracking the
// column and passing escape sequences through unmapped; other high bytes go to
// Roman-8 unless bypass is set. A request making n bytes holds the single output
// register until its last byte leaves (one byte for most inputs, two for newline, up
// to eight for a tab); the next request is taken in the same cycle as the final byte
// of the previous one leaves, so unstalled ordinary text flows at one byte per cycle.

module printer_text_filter_roman8_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire ptfr8_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output ptfr8_pkg::t_out_item       o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_wdata
);

    ptfr8_pkg::t_dp_cmd    cmd;
    ptfr8_pkg::t_dp_status status;

    ptfr8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ptfr8_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_data  (o_out_data),
        .o_status    (status)
    );

endmodule

`default_nettype wire

>>> sim/tb_printer_text_filter_roman8_unit.sv
`default_nettype none

module tb_printer_text_filter_roman8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ptfr8_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int REPORT_MAX     = 10;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_vld = 1'b0;
    t_in_item  in_pay = '0;
    logic      out_stall = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      rx_hold_go = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item out_data;

    printer_text_filter_roman8_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_vld),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_pay),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    t_in_item    pending_chars[$];
    t_out_item   printer_bytes_due[$];
    logic [15:0] column_model = '0;
    logic [1:0]  esc_model = ESC_NONE;
    logic        bypass_model = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        tx_pause = 1'b0;
    int          hold_left = 0;
    int          requests_taken = 0;
    int          bytes_checked = 0;
    int          mismatch_cnt = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void advance_column(input int unsigned n);
        logic [16:0] sum;
        sum = {1'b0, column_model} + 17'(n);
        column_model = sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    // Computes the printer bytes one request produces and queues them.
    function automatic void predict_printer_bytes(input t_in_item req);
        logic [7:0]  b;
        logic [7:0]  outs[$];
        logic [6:0]  low7;
        int unsigned spaces;
        t_out_item   r;
        b = req.in_byte;
        if (req.start_of_file) esc_model = ESC_NONE;
        if (esc_model == ESC_FIRST) begin
            outs.push_back(b);
            if (b == CH_LOWZ || b == CH_EQ || (b >= CH_AT && b <= CH_UPZ))
                esc_model = ESC_NONE;
            else
                esc_model = ESC_BODY;
        end else if (esc_model != ESC_NONE) begin
            outs.push_back(b);
            if (b >= CH_AT && b <= CH_UPZ) esc_model = ESC_NONE;
        end else if (b == CH_BS) begin
            outs.push_back(CH_BS);
            if (column_model != 0) column_model = column_model - 1'b1;
        end else if (b == CH_TAB) begin
            spaces = 8 - column_model[2:0];
            for (int i = 0; i < spaces; i++) outs.push_back(CH_SPACE);
            advance_column(spaces);
        end else if (b == CH_LF) begin
            outs.push_back(CH_LF);
            outs.push_back(CH_CR);
            column_model = '0;
        end else if (b == CH_CR) begin
            outs.push_back(CH_CR);
            column_model = '0;
        end else if (b == CH_ESC) begin
            outs.push_back(CH_ESC);
            esc_model = ESC_FIRST;
        end else begin
            if (b >= HIGH_BASE && !bypass_model) b = ROMAN8_MAP[b - HIGH_BASE];
            outs.push_back(b);
            low7 = b[6:0];
            if (low7 >= 7'h20 && low7 != 7'h7F) advance_column(1);
        end
        foreach (outs[k]) begin
            r.out_byte = outs[k];
            r.last     = (k == outs.size() - 1);
            printer_bytes_due.push_back(r);
        end
    endfunction

    // Request driver: the payload holds while the block stalls it.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_vld <= 1'b0;
        end else begin
            if (in_vld && !o_in_stall) begin
                predict_printer_bytes(in_pay);
                requests_taken++;
            end
            if (!in_vld || !o_in_stall) begin
                if (pending_chars.size() != 0 && !tx_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_vld <= 1'b1;
                    in_pay <= pending_chars.pop_front();
                end else begin
                    in_vld <= 1'b0;
                end
            end
        end
    end

    // Printer side: random stalls plus a single long hold-off.
    always @(posedge i_clk) begin
        if (rx_hold_go) begin
            hold_left <= RX_HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        out_stall <= rx_hold_go || (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            bytes_checked++;
            if (printer_bytes_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected printer byte %02h last %0b", out_data.out_byte,
                             out_data.last);
            end else begin
                want = printer_bytes_due.pop_front();
                if (want.out_byte !== out_data.out_byte || want.last !== out_data.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("printer byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.out_byte, want.last, out_data.out_byte, out_data.last);
                end
            end
        end
    end

    task automatic push_char(input logic [7:0] b, input logic sof);
        t_in_item req;
        req.in_byte       = b;
        req.start_of_file = sof;
        pending_chars.push_back(req);
    endtask

    function automatic logic random_sof();
        return ($urandom_range(15) == 0);
    endfunction

    // Mostly well-formed text and escape sequences, with some raw noise and
    // sequences that are cut short.
    task automatic queue_random_text(input int count);
        int made;
        int pick;
        int body;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 38) begin
                push_char(8'($urandom_range(8'h7E, 8'h20)), random_sof());
                made++;
            end else if (pick < 55) begin
                push_char(8'($urandom_range(8'hFF, 8'hA0)), random_sof());
                made++;
            end else if (pick < 68) begin
                case ($urandom_range(3))
                    0: push_char(CH_BS, random_sof());
                    1: push_char(CH_TAB, random_sof());
                    2: push_char(CH_LF, random_sof());
                    default: push_char(CH_CR, random_sof());
                endcase
                made++;
            end else if (pick < 85) begin
                push_char(CH_ESC, random_sof());
                made++;
                case ($urandom_range(3))
                    0: push_char(CH_LOWZ, 1'b0);
                    1: push_char(8'($urandom_range(CH_UPZ, CH_AT)), 1'b0);
                    default: push_char(8'($urandom_range(8'h3F, 8'h21)), 1'b0);
                endcase
                made++;
                body = $urandom_range(4);
                for (int i = 0; i < body; i++) begin
                    if ($urandom_range(1) == 0)
                        push_char(8'($urandom_range(8'h3F, 8'h21)), 1'b0);
                    else
                        push_char(8'($urandom_range(8'h7E, 8'h60)), 1'b0);
                    made++;
                end
                if ($urandom_range(99) < 85) begin
                    push_char(8'($urandom_range(CH_UPZ, CH_AT)), 1'b0);
                    made++;
                end
            end else begin
                push_char(8'($urandom_range(255)), random_sof());
                made++;
            end
        end
    endtask

    // The emptiness check is repeated after the settling cycles, since a request
    // popped at the same edge as the check is not yet visible as valid.
    task automatic wait_drained();
        do begin
            while (pending_chars.size() != 0 || in_vld || printer_bytes_due.size() != 0)
                @(posedge i_clk);
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end while (pending_chars.size() != 0 || in_vld || printer_bytes_due.size() != 0);
    endtask

    task automatic write_bypass(input logic value);
        wait_drained();
        @(posedge i_clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= value;
        bypass_model  = value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        write_bypass(1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(HIGH_BASE, 1'b0);
        push_char(8'hA6, 1'b0);
        push_char(CH_DEL, 1'b0);
        push_char(8'h9F, 1'b0);
        push_char("A", 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char(CH_BS, 1'b0);
        push_char(CH_CR, 1'b0);
        // Backspace at column zero must leave the column alone.
        push_char(CH_BS, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char(CH_ESC, 1'b0);
        push_char(CH_LOWZ, 1'b0);
        push_char(CH_ESC, 1'b0);
        push_char(CH_EQ, 1'b0);
        // A long sequence: control bytes and a lowercase z inside it pass as data.
        push_char(CH_ESC, 1'b0);
        push_char("(", 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char(CH_ESC, 1'b0);
        push_char(CH_LOWZ, 1'b0);
        push_char("B", 1'b0);
        push_char(CH_ESC, 1'b0);
        push_char("(", 1'b0);
        push_char("a", 1'b1);

        write_bypass(1'b1);
        queue_random_text(72);

        write_bypass(1'b0);
        send_idle_pct = 66;
        queue_random_text(72);

        write_bypass(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        queue_random_text(36);
        wait_drained();
        recv_stall_pct = 0;
        queue_random_text(36);
        @(posedge i_clk);
        rx_hold_go <= 1'b1;
        @(posedge i_clk);
        rx_hold_go <= 1'b0;

        write_bypass(1'b0);
        send_idle_pct  = 7;
        recv_stall_pct = 7;
        queue_random_text(72);
        while (pending_chars.size() > 30) @(posedge i_clk);
        tx_pause = 1'b1;
        while (in_vld || printer_bytes_due.size() != 0) @(posedge i_clk);
        tx_pause = 1'b0;

        // Tabs and backspace from the start of a line and from odd columns.
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        push_char(CH_CR, 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char(CH_BS, 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char("x", 1'b0);
        push_char(CH_TAB, 1'b0);
        push_char(CH_LF, 1'b0);
        push_char(CH_TAB, 1'b0);

        wait_drained();
        mismatch_cnt += printer_bytes_due.size();
        $display("%0d requests and %0d printer bytes checked over idle, stall and hold-off phases",
                 requests_taken, bytes_checked);
        $display("Roman-8 mapping on and off, escape sequences and tab stops included");
        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_cnt);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
